### rtl/msrq_pkg.sv
package msrq_pkg;

  localparam int SLOTS_DEFAULT          = 16;
  localparam int SLOT_BYTES_MAX_DEFAULT = 64;

  localparam int LEN_W      = 7;
  localparam int OFFSET_W   = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [4:0] SLOTS_IN_USE_RESET = 5'd16;
  localparam logic [6:0] SLOT_BYTES_RESET   = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES   = 1'b1;

  typedef enum logic [1:0] {
    ACT_PUSH,
    ACT_READ,
    ACT_POP,
    ACT_NOP
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_FULL,
    STAT_TOO_LARGE,
    STAT_EMPTY
  } status_t;

  typedef enum logic [1:0] {
    DROP_NONE,
    DROP_FULL,
    DROP_LARGE
  } drop_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [7:0]          data_byte;
    logic                has_byte;
    logic                byte_last;
    logic [OFFSET_W-1:0] read_offset;
  } req_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] head_length;
    logic [7:0]       read_byte;
    logic             message_done;
  } rsp_item_t;

  typedef struct packed {
    logic byte_we;
    logic len_we;
    logic rd_en;
  } mem_cmd_t;

  typedef struct packed {
    logic                valid;
    logic                is_read;
    logic [1:0]          status;
    logic                done;
    logic [OFFSET_W-1:0] offset;
  } res_meta_t;

endpackage

### rtl/message_slot_ring_queue_core.sv
// Ring of fixed-size message slots held in a byte memory and a length memory.
// A transaction's result is registered and valid in the cycle after it is accepted.
// Throughput: one transaction per cycle while results are taken; the registered memory read sets the latency.
// A stalled result holds req_ready low until it is taken.
// Reset (rst, synchronous): pointers, fill count, drop state, config registers and result valid reset;
// memory contents are left as they are, with no clearing pass.
module message_slot_ring_queue_core #(
  parameter int SLOTS          = msrq_pkg::SLOTS_DEFAULT,
  parameter int SLOT_BYTES_MAX = msrq_pkg::SLOT_BYTES_MAX_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [msrq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msrq_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  msrq_pkg::req_item_t               req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output msrq_pkg::rsp_item_t               rsp
);

  localparam int PW = $clog2(SLOTS);
  localparam int NW = $clog2(SLOTS + 1);

  logic [4:0]                 slots_in_use;
  logic [6:0]                 slot_bytes;
  logic [NW-1:0]              ring_n;
  logic [msrq_pkg::LEN_W-1:0] cap;

  msrq_pkg::res_meta_t            meta;
  msrq_pkg::mem_cmd_t             cmd;
  logic [PW-1:0]                  wr_slot;
  logic [msrq_pkg::LEN_W-1:0]     wr_offset;
  logic [7:0]                     wr_byte;
  logic [msrq_pkg::LEN_W-1:0]     wr_len;
  logic [PW-1:0]                  rd_slot;
  logic [msrq_pkg::OFFSET_W-1:0]  rd_offset;
  logic [7:0]                     rd_byte;
  logic [msrq_pkg::LEN_W-1:0]     rd_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= msrq_pkg::SLOTS_IN_USE_RESET;
      slot_bytes   <= msrq_pkg::SLOT_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        msrq_pkg::CFG_SLOTS_IN_USE: begin
          slots_in_use <= cfg_data[4:0];
        end
        msrq_pkg::CFG_SLOT_BYTES: begin
          slot_bytes <= cfg_data[6:0];
        end
        default: begin
          slot_bytes <= slot_bytes;
        end
      endcase
    end
  end

  always_comb begin
    if (slots_in_use < 5'd2) begin
      ring_n = NW'(2);
    end else if (32'(slots_in_use) > SLOTS) begin
      ring_n = NW'(SLOTS);
    end else begin
      ring_n = NW'(slots_in_use);
    end
    if (32'(slot_bytes) > SLOT_BYTES_MAX) begin
      cap = msrq_pkg::LEN_W'(SLOT_BYTES_MAX);
    end else begin
      cap = slot_bytes;
    end
  end

  msrq_ctrl #(
    .SLOTS          (SLOTS),
    .SLOT_BYTES_MAX (SLOT_BYTES_MAX)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .ring_n    (ring_n),
    .cap       (cap),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_ready (rsp_ready),
    .meta      (meta),
    .cmd       (cmd),
    .wr_slot   (wr_slot),
    .wr_offset (wr_offset),
    .wr_byte   (wr_byte),
    .wr_len    (wr_len),
    .rd_slot   (rd_slot),
    .rd_offset (rd_offset)
  );

  msrq_store #(
    .SLOTS          (SLOTS),
    .SLOT_BYTES_MAX (SLOT_BYTES_MAX)
  ) u_store (
    .clk       (clk),
    .cmd       (cmd),
    .wr_slot   (wr_slot),
    .wr_offset (wr_offset),
    .wr_byte   (wr_byte),
    .wr_len    (wr_len),
    .rd_slot   (rd_slot),
    .rd_offset (rd_offset),
    .rd_byte   (rd_byte),
    .rd_len    (rd_len)
  );

  assign rsp_valid = meta.valid;

  always_comb begin
    rsp.status       = meta.status;
    rsp.message_done = meta.done;
    rsp.head_length  = '0;
    rsp.read_byte    = '0;
    if (meta.is_read) begin
      rsp.head_length = rd_len;
      if (msrq_pkg::LEN_W'(meta.offset) < rd_len) begin
        rsp.read_byte = rd_byte;
      end
    end
  end

endmodule

### rtl/msrq_store.sv
module msrq_store #(
  parameter int SLOTS          = msrq_pkg::SLOTS_DEFAULT,
  parameter int SLOT_BYTES_MAX = msrq_pkg::SLOT_BYTES_MAX_DEFAULT
) (
  input  logic                           clk,
  input  msrq_pkg::mem_cmd_t             cmd,
  input  logic [$clog2(SLOTS)-1:0]       wr_slot,
  input  logic [msrq_pkg::LEN_W-1:0]     wr_offset,
  input  logic [7:0]                     wr_byte,
  input  logic [msrq_pkg::LEN_W-1:0]     wr_len,
  input  logic [$clog2(SLOTS)-1:0]       rd_slot,
  input  logic [msrq_pkg::OFFSET_W-1:0]  rd_offset,
  output logic [7:0]                     rd_byte,
  output logic [msrq_pkg::LEN_W-1:0]     rd_len
);

  localparam int DEPTH = SLOTS * SLOT_BYTES_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]                 byte_mem [DEPTH];
  logic [msrq_pkg::LEN_W-1:0] len_mem  [SLOTS];

  logic [AW-1:0] byte_waddr;
  logic [AW-1:0] byte_raddr;

  assign byte_waddr = AW'(32'(wr_slot) * SLOT_BYTES_MAX + 32'(wr_offset));
  assign byte_raddr = AW'(32'(rd_slot) * SLOT_BYTES_MAX + 32'(rd_offset));

  always_ff @(posedge clk) begin
    if (cmd.byte_we) begin
      byte_mem[byte_waddr] <= wr_byte;
    end
    if (cmd.rd_en) begin
      rd_byte <= byte_mem[byte_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.len_we) begin
      len_mem[wr_slot] <= wr_len;
    end
    if (cmd.rd_en) begin
      rd_len <= len_mem[rd_slot];
    end
  end

endmodule

### rtl/msrq_ctrl.sv
module msrq_ctrl #(
  parameter int SLOTS          = msrq_pkg::SLOTS_DEFAULT,
  parameter int SLOT_BYTES_MAX = msrq_pkg::SLOT_BYTES_MAX_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [$clog2(SLOTS+1)-1:0]     ring_n,
  input  logic [msrq_pkg::LEN_W-1:0]     cap,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  msrq_pkg::req_item_t            req,
  input  logic                           rsp_ready,
  output msrq_pkg::res_meta_t            meta,
  output msrq_pkg::mem_cmd_t             cmd,
  output logic [$clog2(SLOTS)-1:0]       wr_slot,
  output logic [msrq_pkg::LEN_W-1:0]     wr_offset,
  output logic [7:0]                     wr_byte,
  output logic [msrq_pkg::LEN_W-1:0]     wr_len,
  output logic [$clog2(SLOTS)-1:0]       rd_slot,
  output logic [msrq_pkg::OFFSET_W-1:0]  rd_offset
);

  localparam int PW = $clog2(SLOTS);
  localparam int RESET_N = (SLOTS < 16) ? SLOTS : 16;
  localparam logic [PW-1:0] CONSUMED_RESET = PW'(RESET_N - 1);

  logic [PW-1:0]              consumed_ptr, consumed_ptr_next;
  logic [PW-1:0]              free_ptr, free_ptr_next;
  logic [msrq_pkg::LEN_W-1:0] fill_count, fill_count_next;
  msrq_pkg::drop_t            drop, drop_next;

  logic                       accept;
  logic [PW-1:0]              head;
  logic [msrq_pkg::LEN_W-1:0] fill_inc;
  logic [1:0]                 status;
  logic                       done;
  logic                       is_read;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                            input logic [$clog2(SLOTS+1)-1:0] n);
    logic [PW:0] q;
    q = {1'b0, p} + 1'b1;
    if (32'(q) >= 32'(n)) begin
      return '0;
    end
    return q[PW-1:0];
  endfunction

  assign req_ready = !meta.valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign head      = advance(consumed_ptr, ring_n);
  assign fill_inc  = fill_count + 1'b1;

  assign wr_slot   = free_ptr;
  assign wr_offset = fill_count;
  assign wr_byte   = req.data_byte;
  assign rd_slot   = head;
  assign rd_offset = req.read_offset;

  always_comb begin
    consumed_ptr_next = consumed_ptr;
    free_ptr_next     = free_ptr;
    fill_count_next   = fill_count;
    drop_next         = drop;
    cmd               = '0;
    wr_len            = fill_count;
    status            = msrq_pkg::STAT_OK;
    done              = 1'b0;
    is_read           = 1'b0;
    case (msrq_pkg::action_t'(req.action))
      msrq_pkg::ACT_PUSH: begin
        if (drop == msrq_pkg::DROP_NONE && fill_count == '0 && free_ptr == consumed_ptr) begin
          drop_next = msrq_pkg::DROP_FULL;
        end
        if (drop_next == msrq_pkg::DROP_NONE && req.has_byte) begin
          if (fill_count >= cap) begin
            drop_next       = msrq_pkg::DROP_LARGE;
            fill_count_next = '0;
          end else begin
            cmd.byte_we     = accept;
            fill_count_next = fill_inc;
          end
        end
        wr_len = fill_count_next;
        case (drop_next)
          msrq_pkg::DROP_FULL: begin
            status = msrq_pkg::STAT_FULL;
          end
          msrq_pkg::DROP_LARGE: begin
            status = msrq_pkg::STAT_TOO_LARGE;
          end
          default: begin
            status = msrq_pkg::STAT_OK;
          end
        endcase
        if (drop_next != msrq_pkg::DROP_NONE) begin
          if (req.byte_last) begin
            drop_next = msrq_pkg::DROP_NONE;
          end
        end else if (req.byte_last) begin
          cmd.len_we      = accept;
          free_ptr_next   = advance(free_ptr, ring_n);
          fill_count_next = '0;
          done            = 1'b1;
        end
      end
      msrq_pkg::ACT_READ, msrq_pkg::ACT_POP: begin
        if (head == free_ptr) begin
          status = msrq_pkg::STAT_EMPTY;
        end else if (msrq_pkg::action_t'(req.action) == msrq_pkg::ACT_READ) begin
          cmd.rd_en = accept;
          is_read   = 1'b1;
        end else begin
          consumed_ptr_next = head;
        end
      end
      default: begin
        status = msrq_pkg::STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      consumed_ptr <= CONSUMED_RESET;
      free_ptr     <= '0;
      fill_count   <= '0;
      drop         <= msrq_pkg::DROP_NONE;
      meta.valid   <= 1'b0;
    end else begin
      if (accept) begin
        consumed_ptr <= consumed_ptr_next;
        free_ptr     <= free_ptr_next;
        fill_count   <= fill_count_next;
        drop         <= drop_next;
        meta.valid   <= 1'b1;
      end else if (rsp_ready) begin
        meta.valid   <= 1'b0;
      end
    end
    if (accept) begin
      meta.is_read <= is_read;
      meta.status  <= status;
      meta.done    <= done;
      meta.offset  <= req.read_offset;
    end
  end

endmodule

### rtl/msrq_checker.sv
module msrq_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input msrq_pkg::rsp_item_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("accepted transaction gave no result next cycle");

  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.message_done |-> rsp.status == msrq_pkg::STAT_OK)
    else $error("commit reported with a failing status");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != msrq_pkg::STAT_OK
      |-> rsp.head_length == '0 && rsp.read_byte == '0)
    else $error("failing status carries read data");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind message_slot_ring_queue_core msrq_checker u_msrq_checker (.*);

### tb/message_slot_ring_queue_core_tb.sv
`timescale 1ns / 100ps
module message_slot_ring_queue_core_tb;

  localparam int RING_SLOTS      = msrq_pkg::SLOTS_DEFAULT;
  localparam int SLOT_CAP        = msrq_pkg::SLOT_BYTES_MAX_DEFAULT;
  localparam int OFF_W           = msrq_pkg::OFFSET_W;
  localparam int CFG_W           = msrq_pkg::CFG_DATA_W;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int QUIET_LIMIT     = 2000;
  localparam int ITEM_BUDGET     = 800;
  localparam int REPORT_LIMIT    = 10;

  logic                            clk;
  logic                            rst       = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [msrq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [msrq_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            req_valid = 1'b0;
  logic                            req_ready;
  msrq_pkg::req_item_t             req       = '0;
  logic                            rsp_valid;
  logic                            rsp_ready = 1'b0;
  msrq_pkg::rsp_item_t             rsp;

  bit no_idle;
  bit hold_off_pending;
  int items_sent;
  int bad_replies;

  logic [4:0]          ring_slots_reg;
  logic [6:0]          msg_cap_reg;
  int                  retired_ptr;
  int                  write_slot;
  int                  fill_bytes;
  msrq_pkg::drop_t     drop_mode;
  logic [7:0]          slot_data [RING_SLOTS*SLOT_CAP];
  logic [6:0]          slot_len [RING_SLOTS];
  msrq_pkg::rsp_item_t expected_replies [$];

  message_slot_ring_queue_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom);
  endfunction

  function automatic logic [OFF_W-1:0] rand_off();
    return OFF_W'($urandom);
  endfunction

  function automatic logic [CFG_W-1:0] rand_cfg();
    return CFG_W'($urandom);
  endfunction

  function automatic int ring_len();
    int n;
    n = ring_slots_reg;
    if (n < 2) n = 2;
    if (n > RING_SLOTS) n = RING_SLOTS;
    return n;
  endfunction

  function automatic int next_slot(int p);
    return (p + 1 >= ring_len()) ? 0 : p + 1;
  endfunction

  function automatic void clear_queue_state();
    ring_slots_reg = msrq_pkg::SLOTS_IN_USE_RESET;
    msg_cap_reg    = msrq_pkg::SLOT_BYTES_RESET;
    retired_ptr    = ring_len() - 1;
    write_slot     = 0;
    fill_bytes     = 0;
    drop_mode      = msrq_pkg::DROP_NONE;
  endfunction

  function automatic msrq_pkg::rsp_item_t apply_queue_op(msrq_pkg::req_item_t op);
    msrq_pkg::rsp_item_t r;
    int                  cap;
    int                  head;
    r = '0;
    cap = (msg_cap_reg > SLOT_CAP) ? SLOT_CAP : msg_cap_reg;
    case (msrq_pkg::action_t'(op.action))
      msrq_pkg::ACT_PUSH: begin
        if (drop_mode == msrq_pkg::DROP_NONE && fill_bytes == 0 && write_slot == retired_ptr)
          drop_mode = msrq_pkg::DROP_FULL;
        if (drop_mode == msrq_pkg::DROP_NONE && op.has_byte) begin
          if (fill_bytes >= cap) begin
            drop_mode  = msrq_pkg::DROP_LARGE;
            fill_bytes = 0;
          end else begin
            slot_data[write_slot*SLOT_CAP + fill_bytes] = op.data_byte;
            fill_bytes++;
          end
        end
        if (drop_mode != msrq_pkg::DROP_NONE) begin
          r.status = (drop_mode == msrq_pkg::DROP_FULL) ? msrq_pkg::STAT_FULL :
                                                          msrq_pkg::STAT_TOO_LARGE;
          if (op.byte_last) drop_mode = msrq_pkg::DROP_NONE;
        end else if (op.byte_last) begin
          slot_len[write_slot] = 7'(fill_bytes);
          write_slot           = next_slot(write_slot);
          fill_bytes           = 0;
          r.message_done       = 1'b1;
        end
      end
      msrq_pkg::ACT_READ, msrq_pkg::ACT_POP: begin
        head = next_slot(retired_ptr);
        if (head == write_slot) begin
          r.status = msrq_pkg::STAT_EMPTY;
        end else if (op.action == msrq_pkg::ACT_READ) begin
          r.head_length = slot_len[head];
          if (op.read_offset < slot_len[head])
            r.read_byte = slot_data[head*SLOT_CAP + op.read_offset];
        end else begin
          retired_ptr = head;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    msrq_pkg::rsp_item_t want;
    if (rst) begin
      clear_queue_state();
      expected_replies.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_replies.size() == 0) begin
          bad_replies++;
          if (bad_replies <= REPORT_LIMIT)
            $display("unexpected transaction: status %0d head_length %0d %s %02h done %0b",
                     rsp.status, rsp.head_length, "read_byte", rsp.read_byte,
                     rsp.message_done);
        end else begin
          want = expected_replies.pop_front();
          if (rsp.status !== want.status || rsp.head_length !== want.head_length ||
              rsp.read_byte !== want.read_byte || rsp.message_done !== want.message_done) begin
            bad_replies++;
            if (bad_replies <= REPORT_LIMIT)
              $display("mismatch: status %0d/%0d head_length %0d/%0d %s %02h/%02h %s %0b/%0b",
                       want.status, rsp.status, want.head_length, rsp.head_length,
                       "read_byte", want.read_byte, rsp.read_byte, "done",
                       want.message_done, rsp.message_done);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == msrq_pkg::CFG_SLOTS_IN_USE) ring_slots_reg = cfg_data[4:0];
        else msg_cap_reg = cfg_data;
      end
      if (req_valid && req_ready) expected_replies.push_back(apply_queue_op(req));
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left   = 0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        stall_left       = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          stall_left = pick_gap();
          run_left   = $urandom_range(0, 12);
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic msrq_pkg::req_item_t make_op(msrq_pkg::action_t a, logic [7:0] d,
                                                  logic h, logic l, logic [OFF_W-1:0] off);
    msrq_pkg::req_item_t it;
    it.action      = a;
    it.data_byte   = d;
    it.has_byte    = h;
    it.byte_last   = l;
    it.read_offset = off;
    return it;
  endfunction

  task automatic send_item(input msrq_pkg::req_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= it;
    do @(posedge clk); while (!req_ready);
    items_sent++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [msrq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_ring(input logic [CFG_W-1:0] slots, input logic [CFG_W-1:0] cap);
    wait_drained();
    repeat (2) @(posedge clk);
    write_reg(msrq_pkg::CFG_SLOTS_IN_USE, slots);
    write_reg(msrq_pkg::CFG_SLOT_BYTES, cap);
  endtask

  task automatic push_message(input int len);
    int k;
    bit tail_blank;
    tail_blank = (len > 0) && ($urandom_range(0, 7) == 0);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 15) == 0)
        send_item(make_op(msrq_pkg::ACT_PUSH, rand_byte(), 1'b0, 1'b0, rand_off()));
      send_item(make_op(msrq_pkg::ACT_PUSH, rand_byte(), 1'b1, (k == len - 1) && !tail_blank,
                        rand_off()));
    end
    if (len == 0 || tail_blank)
      send_item(make_op(msrq_pkg::ACT_PUSH, rand_byte(), 1'b0, 1'b1, rand_off()));
  endtask

  task automatic random_traffic(input int n);
    int               stop_at;
    int               pick;
    int               len;
    logic [31:0]      raw;
    logic [OFF_W-1:0] off;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      off  = $urandom_range(0, 1) ? OFF_W'($urandom_range(0, 7)) : rand_off();
      if (pick < 35) begin
        len = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 6) : $urandom_range(7, 70);
        push_message(len);
      end else if (pick < 60) begin
        send_item(make_op(msrq_pkg::ACT_READ, rand_byte(), rand_bit(), rand_bit(), off));
      end else if (pick < 85) begin
        send_item(make_op(msrq_pkg::ACT_POP, rand_byte(), rand_bit(), rand_bit(), off));
      end else if (pick < 90) begin
        send_item(make_op(msrq_pkg::ACT_NOP, rand_byte(), rand_bit(), rand_bit(), off));
      end else begin
        raw = $urandom;
        send_item(msrq_pkg::req_item_t'(raw[$bits(msrq_pkg::req_item_t)-1:0]));
      end
    end
  endtask

  task automatic test_empty_ring();
    send_item(make_op(msrq_pkg::ACT_READ, 8'h00, 1'b0, 1'b0, 6'd0));
    send_item(make_op(msrq_pkg::ACT_POP, 8'h00, 1'b0, 1'b0, 6'd0));
    send_item(make_op(msrq_pkg::ACT_NOP, 8'hFF, 1'b1, 1'b1, 6'h3F));
    send_item(make_op(msrq_pkg::ACT_PUSH, 8'hFF, 1'b0, 1'b1, 6'h3F));
    send_item(make_op(msrq_pkg::ACT_READ, 8'h00, 1'b0, 1'b0, 6'd0));
    send_item(make_op(msrq_pkg::ACT_READ, 8'h00, 1'b0, 1'b0, 6'h3F));
    send_item(make_op(msrq_pkg::ACT_POP, 8'h00, 1'b0, 1'b0, 6'd0));
    send_item(make_op(msrq_pkg::ACT_POP, 8'h00, 1'b0, 1'b0, 6'd0));
  endtask

  task automatic test_byte_values();
    send_item(make_op(msrq_pkg::ACT_PUSH, 8'h00, 1'b1, 1'b0, 6'd0));
    send_item(make_op(msrq_pkg::ACT_PUSH, 8'hFF, 1'b0, 1'b0, 6'd0));
    send_item(make_op(msrq_pkg::ACT_PUSH, 8'hFF, 1'b1, 1'b0, 6'd0));
    send_item(make_op(msrq_pkg::ACT_PUSH, 8'h5A, 1'b1, 1'b1, 6'd0));
    send_item(make_op(msrq_pkg::ACT_READ, 8'h00, 1'b0, 1'b0, 6'd0));
    send_item(make_op(msrq_pkg::ACT_READ, 8'h00, 1'b0, 1'b0, 6'd1));
    send_item(make_op(msrq_pkg::ACT_READ, 8'h00, 1'b0, 1'b0, 6'd2));
    send_item(make_op(msrq_pkg::ACT_READ, 8'h00, 1'b0, 1'b0, 6'd3));
    send_item(make_op(msrq_pkg::ACT_POP, 8'h00, 1'b0, 1'b0, 6'd0));
  endtask

  // fill every slot once so later ring-size changes never expose an unwritten slot
  task automatic test_fill_ring();
    int k;
    for (k = 0; k < RING_SLOTS - 1; k++) push_message($urandom_range(0, 3));
    for (k = 0; k < 3; k++)
      send_item(make_op(msrq_pkg::ACT_PUSH, rand_byte(), 1'b1, k == 2, rand_off()));
    for (k = 0; k < RING_SLOTS - 1; k++) begin
      send_item(make_op(msrq_pkg::ACT_READ, rand_byte(), rand_bit(), rand_bit(),
                        OFF_W'($urandom_range(0, 3))));
      send_item(make_op(msrq_pkg::ACT_POP, rand_byte(), rand_bit(), rand_bit(), rand_off()));
    end
    send_item(make_op(msrq_pkg::ACT_POP, rand_byte(), rand_bit(), rand_bit(), rand_off()));
    push_message(2);
    send_item(make_op(msrq_pkg::ACT_READ, rand_byte(), rand_bit(), rand_bit(), 6'd1));
    send_item(make_op(msrq_pkg::ACT_POP, rand_byte(), rand_bit(), rand_bit(), rand_off()));
  endtask

  task automatic test_too_large();
    int k;
    set_ring(7'd16, 7'd2);
    push_message(2);
    for (k = 0; k < 4; k++)
      send_item(make_op(msrq_pkg::ACT_PUSH, rand_byte(), 1'b1, k == 3, rand_off()));
    push_message(0);
    set_ring(7'd16, 7'd0);
    send_item(make_op(msrq_pkg::ACT_PUSH, rand_byte(), 1'b1, 1'b1, rand_off()));
    push_message(0);
    set_ring(7'd16, 7'd127);
    for (k = 0; k < 3; k++)
      send_item(make_op(msrq_pkg::ACT_POP, rand_byte(), rand_bit(), rand_bit(), rand_off()));
    push_message(64);
    send_item(make_op(msrq_pkg::ACT_READ, rand_byte(), rand_bit(), rand_bit(), 6'h3F));
    push_message(65);
    send_item(make_op(msrq_pkg::ACT_POP, rand_byte(), rand_bit(), rand_bit(), rand_off()));
    send_item(make_op(msrq_pkg::ACT_POP, rand_byte(), rand_bit(), rand_bit(), rand_off()));
  endtask

  task automatic test_config_sweep();
    logic [6:0] slot_vals [9] = '{7'd2, 7'd16, 7'd0, 7'd1, 7'h7F, 7'd3, 7'h45, 7'd9, 7'd16};
    logic [6:0] cap_vals  [9] = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd5, 7'd64, 7'd3, 7'd17, 7'd64};
    int k;
    for (k = 0; k < 9; k++) begin
      set_ring(slot_vals[k], cap_vals[k]);
      random_traffic(50);
    end
    set_ring(rand_cfg(), rand_cfg());
    random_traffic(40);
  endtask

  task automatic test_backpressure();
    set_ring(7'd16, 7'd64);
    hold_off_pending = 1'b1;
    no_idle          = 1'b1;
    random_traffic(40);
    no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic test_soak();
    set_ring(CFG_W'($urandom_range(2, 16)), CFG_W'($urandom_range(1, 64)));
    random_traffic(80);
    no_idle = 1'b1;
    random_traffic(60);
    no_idle = 1'b0;
    if (items_sent < ITEM_BUDGET) random_traffic(ITEM_BUDGET - items_sent);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_ring();
    test_byte_values();
    test_fill_ring();
    test_too_large();
    test_config_sweep();
    test_backpressure();
    test_soak();
    wait_drained();
    repeat (4) @(posedge clk);
    if (bad_replies == 0 && expected_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
rtl/msrq_pkg.sv
rtl/msrq_store.sv
rtl/msrq_ctrl.sv
rtl/message_slot_ring_queue_core.sv
rtl/msrq_checker.sv
tb/message_slot_ring_queue_core_tb.sv
